// ===== hw/rtl/grsf_pkg.sv =====
package grsf_pkg;

   localparam logic [63:0] DBL_ONE         = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] DBL_ZERO        = 64'h0000_0000_0000_0000;
   localparam logic [63:0] DBL_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
   localparam logic [63:0] DBL_MAXG_RESET  = 64'h4059_0000_0000_0000;
   localparam logic [63:0] DBL_LIM_RESET   = 64'h40C3_8800_0000_0000;
   localparam logic [10:0] EXP_ALL_ONES    = 11'h7FF;

   localparam logic [1:0] KIND_OBJECTIVE = 2'd0;
   localparam logic [1:0] KIND_CLEAR     = 2'd3;

   localparam logic REG_TARGET_PEAK = 1'b0;
   localparam logic REG_CLAMP_BOUND = 1'b1;

   typedef struct packed {
      logic take_item;
      logic start_raw;
      logic start_lo;
      logic take_raw;
      logic take_lo;
      logic set_one;
      logic pick;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic closes;
      logic norm_bad;
      logic raw_amp;
      logic div_done;
      logic out_free;
   } status_type;

   function automatic logic fp_is_nan(input logic [63:0] a);
      return (a[62:52] == EXP_ALL_ONES) && (a[51:0] != 52'd0);
   endfunction

   function automatic logic fp_lt(input logic [63:0] a, input logic [63:0] b);
      logic result;
      if (fp_is_nan(a) || fp_is_nan(b)) begin
         result = 1'b0;
      end else if ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)) begin
         result = 1'b0;
      end else if (a[63] != b[63]) begin
         result = a[63];
      end else if (!a[63]) begin
         result = a[62:0] < b[62:0];
      end else begin
         result = a[62:0] > b[62:0];
      end
      return result;
   endfunction

endpackage

// ===== hw/rtl/gradient_row_scaling_factor_top.sv =====
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tdata entry, tuser kind, tlast end of row
// rsp      out        rsp_tvalid/rsp_tready  tdata three factors, tuser factor kind
// csr      in         APB, pready high       target peak at 0x0, clamp bound at 0x8
// An item that does not close a row, or a clear, is taken while the input stays ready.
// A closing item stalls the input until its result is published. The norm alone may fix the factor;
// otherwise one or two divides run, longer with subnormal operands, on the shared divider
// that normalizes, divides and denormalizes one bit per cycle, used up to twice per row.
// Reset is synchronous and restores the register defaults and the row extremes.
// One finished item waits in the output register while the next row is taken.
module gradient_row_scaling_factor_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [71:0]  req_tdata,   // entry_value[63:0], entry_present[64], zero pad
   input  logic [1:0]   req_tuser,   // kind[1:0]
   input  logic         req_tlast,   // end_of_row
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata,   // scale_factor, least_row_factor, greatest_row_factor
   output logic [1:0]   rsp_tuser,   // factor_kind[1:0]
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);

   grsf_pkg::cmd_type    cmd;
   grsf_pkg::status_type status;

   grsf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   grsf_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata)
   );

   assign csr_pready = 1'b1;

   a_closing_item_stalls_input: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast && (req_tuser != grsf_pkg::KIND_CLEAR)
      |=> !req_tready)
      else $error("input still ready after a closing item");

   a_no_clear_kind_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser != grsf_pkg::KIND_CLEAR))
      else $error("result carries the clear kind");

   a_publish_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> status.out_free)
      else $error("result published over a waiting item");

   a_out_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

// ===== hw/rtl/grsf_fdiv.sv =====
module grsf_fdiv (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic        done,
   output logic [63:0] quotient
);

   typedef enum logic [2:0] {D_IDLE, D_NORM, D_DIV, D_DENORM, D_ROUND} dstate_type;

   localparam logic signed [12:0] EXP_MIN  = -13'sd1022;
   localparam logic signed [12:0] EXP_OVF  = 13'sd1024;
   localparam logic signed [12:0] EXP_BIAS = 13'sd1023;
   localparam logic [5:0]         QBITS    = 6'd54;

   dstate_type        state_ff, state_in;
   logic              sign_ff, sign_in;
   logic [52:0]       ma_ff, ma_in, mb_ff, mb_in;
   logic signed [12:0] xa_ff, xa_in, xb_ff, xb_in, exp_ff, exp_in;
   logic [54:0]       r_ff, r_in;
   logic [53:0]       q_ff, q_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic              sticky_ff, sticky_in;
   logic [63:0]       res_ff, res_in;
   logic              done_ff, done_in;

   logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic signed [12:0] ediff, e2, ebiased;
   logic [54:0] rsub, rnext;
   logic [53:0] mr;
   logic [52:0] mant;
   logic inc;

   always_comb begin
      a_nan  = grsf_pkg::fp_is_nan(num);
      b_nan  = grsf_pkg::fp_is_nan(den);
      a_inf  = (num[62:52] == grsf_pkg::EXP_ALL_ONES) && (num[51:0] == 52'd0);
      b_inf  = (den[62:52] == grsf_pkg::EXP_ALL_ONES) && (den[51:0] == 52'd0);
      a_zero = num[62:0] == 63'd0;
      b_zero = den[62:0] == 63'd0;
      ediff  = xa_ff - xb_ff;
      rsub   = r_ff - {2'b00, mb_ff};
      rnext  = (r_ff >= {2'b00, mb_ff}) ? {rsub[53:0], 1'b0} : {r_ff[53:0], 1'b0};
      inc    = q_ff[0] & (sticky_ff | q_ff[1]);
      mr     = {1'b0, q_ff[53:1]} + {53'd0, inc};
      mant   = mr[53] ? mr[53:1] : mr[52:0];
      e2     = mr[53] ? exp_ff + 13'sd1 : exp_ff;
      ebiased = e2 + EXP_BIAS;

      state_in  = state_ff;
      sign_in   = sign_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      xa_in     = xa_ff;
      xb_in     = xb_ff;
      exp_in    = exp_ff;
      r_in      = r_ff;
      q_in      = q_ff;
      cnt_in    = cnt_ff;
      sticky_in = sticky_ff;
      res_in    = res_ff;
      done_in   = 1'b0;

      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               sign_in   = num[63] ^ den[63];
               sticky_in = 1'b0;
               if (a_nan) begin
                  res_in  = num | 64'h0008_0000_0000_0000;
                  done_in = 1'b1;
               end else if (b_nan) begin
                  res_in  = den | 64'h0008_0000_0000_0000;
                  done_in = 1'b1;
               end else if ((a_inf && b_inf) || (a_zero && b_zero)) begin
                  res_in  = grsf_pkg::DBL_DEFAULT_NAN;
                  done_in = 1'b1;
               end else if (a_inf || b_zero) begin
                  res_in  = {num[63] ^ den[63], grsf_pkg::EXP_ALL_ONES, 52'd0};
                  done_in = 1'b1;
               end else if (a_zero || b_inf) begin
                  res_in  = {num[63] ^ den[63], 63'd0};
                  done_in = 1'b1;
               end else begin
                  ma_in    = {num[62:52] != 11'd0, num[51:0]};
                  mb_in    = {den[62:52] != 11'd0, den[51:0]};
                  xa_in    = (num[62:52] == 11'd0) ? 13'sd1 : $signed({2'b00, num[62:52]});
                  xb_in    = (den[62:52] == 11'd0) ? 13'sd1 : $signed({2'b00, den[62:52]});
                  state_in = D_NORM;
               end
            end
         end
         D_NORM: begin
            if (ma_ff[52] && mb_ff[52]) begin
               if (ma_ff < mb_ff) begin
                  r_in   = {1'b0, ma_ff, 1'b0};
                  exp_in = ediff - 13'sd1;
               end else begin
                  r_in   = {2'b00, ma_ff};
                  exp_in = ediff;
               end
               q_in     = 54'd0;
               cnt_in   = QBITS;
               state_in = D_DIV;
            end else begin
               if (!ma_ff[52]) begin
                  ma_in = {ma_ff[51:0], 1'b0};
                  xa_in = xa_ff - 13'sd1;
               end
               if (!mb_ff[52]) begin
                  mb_in = {mb_ff[51:0], 1'b0};
                  xb_in = xb_ff - 13'sd1;
               end
            end
         end
         D_DIV: begin
            q_in   = {q_ff[52:0], r_ff >= {2'b00, mb_ff}};
            r_in   = rnext;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               sticky_in = rnext != 55'd0;
               state_in  = D_DENORM;
            end
         end
         D_DENORM: begin
            if (exp_ff < EXP_MIN) begin
               if (q_ff == 54'd0) begin
                  exp_in = EXP_MIN;
               end else begin
                  q_in      = {1'b0, q_ff[53:1]};
                  sticky_in = sticky_ff | q_ff[0];
                  exp_in    = exp_ff + 13'sd1;
               end
            end else begin
               state_in = D_ROUND;
            end
         end
         D_ROUND: begin
            if (e2 >= EXP_OVF) begin
               res_in = {sign_ff, grsf_pkg::EXP_ALL_ONES, 52'd0};
            end else begin
               res_in = {sign_ff, mant[52] ? ebiased[10:0] : 11'd0, mant[51:0]};
            end
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      sign_ff   <= sign_in;
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      xa_ff     <= xa_in;
      xb_ff     <= xb_in;
      exp_ff    <= exp_in;
      r_ff      <= r_in;
      q_ff      <= q_in;
      cnt_ff    <= cnt_in;
      sticky_ff <= sticky_in;
      res_ff    <= res_in;
   end

   assign done     = done_ff;
   assign quotient = res_ff;

endmodule

// ===== hw/rtl/grsf_datapath.sv =====
module grsf_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  grsf_pkg::cmd_type    cmd,
   output grsf_pkg::status_type status,
   input  logic [71:0]          req_tdata,
   input  logic [1:0]           req_tuser,
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [191:0]         rsp_tdata,
   output logic [1:0]           rsp_tuser,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [63:0]          csr_pwdata,
   output logic [63:0]          csr_prdata
);

   logic [63:0] maxg_ff, lim_ff, norm_ff, close_norm_ff, least_ff, greatest_ff;
   logic [63:0] raw_ff, lo_ff, f_ff;
   logic        any_ff;
   logic [1:0]  kind_ff;
   logic        out_valid_ff;
   logic [63:0] out_factor_ff, out_least_ff, out_greatest_ff;
   logic [1:0]  out_kind_ff;

   logic [63:0] mag, norm_in, least_in, greatest_in, pick_in;
   logic        div_done;
   logic [63:0] div_q;

   grsf_fdiv u_fdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_raw | cmd.start_lo),
      .num      (cmd.start_lo ? grsf_pkg::DBL_ONE : maxg_ff),
      .den      (cmd.start_lo ? lim_ff : close_norm_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      mag = {1'b0, req_tdata[62:0]};
      norm_in = norm_ff;
      if (req_tdata[64] && !grsf_pkg::fp_is_nan(mag) && (mag[62:0] > norm_ff[62:0])) begin
         norm_in = mag;
      end
      if (grsf_pkg::fp_lt(raw_ff, lo_ff)) begin
         pick_in = lo_ff;
      end else if (grsf_pkg::fp_lt(lim_ff, raw_ff)) begin
         pick_in = lim_ff;
      end else begin
         pick_in = raw_ff;
      end
      least_in    = least_ff;
      greatest_in = greatest_ff;
      if (kind_ff != grsf_pkg::KIND_OBJECTIVE) begin
         if (!any_ff) begin
            least_in    = f_ff;
            greatest_in = f_ff;
         end else begin
            if (grsf_pkg::fp_lt(f_ff, least_ff)) begin
               least_in = f_ff;
            end
            if (grsf_pkg::fp_lt(greatest_ff, f_ff)) begin
               greatest_in = f_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         maxg_ff      <= grsf_pkg::DBL_MAXG_RESET;
         lim_ff       <= grsf_pkg::DBL_LIM_RESET;
         norm_ff      <= grsf_pkg::DBL_ZERO;
         least_ff     <= grsf_pkg::DBL_ONE;
         greatest_ff  <= grsf_pkg::DBL_ONE;
         any_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr[3] == grsf_pkg::REG_TARGET_PEAK) begin
               maxg_ff <= csr_pwdata;
            end else begin
               lim_ff <= csr_pwdata;
            end
         end
         if (cmd.take_item) begin
            if (req_tuser == grsf_pkg::KIND_CLEAR) begin
               least_ff    <= grsf_pkg::DBL_ONE;
               greatest_ff <= grsf_pkg::DBL_ONE;
               any_ff      <= 1'b0;
            end else if (req_tlast) begin
               norm_ff <= grsf_pkg::DBL_ZERO;
            end else begin
               norm_ff <= norm_in;
            end
         end
         if (cmd.publish) begin
            least_ff     <= least_in;
            greatest_ff  <= greatest_in;
            any_ff       <= any_ff | (kind_ff != grsf_pkg::KIND_OBJECTIVE);
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (cmd.take_item && req_tlast) begin
         close_norm_ff <= norm_in;
         kind_ff       <= req_tuser;
      end
      if (cmd.take_raw) begin
         raw_ff <= div_q;
      end
      if (cmd.take_lo) begin
         lo_ff <= div_q;
      end
      if (cmd.set_one) begin
         f_ff <= grsf_pkg::DBL_ONE;
      end else if (cmd.pick) begin
         f_ff <= pick_in;
      end
      if (cmd.publish) begin
         out_factor_ff   <= f_ff;
         out_kind_ff     <= kind_ff;
         out_least_ff    <= least_in;
         out_greatest_ff <= greatest_in;
      end
   end

   always_comb begin
      status.closes   = req_tlast && (req_tuser != grsf_pkg::KIND_CLEAR);
      status.norm_bad = (close_norm_ff[62:0] == 63'd0) ||
                        (close_norm_ff[62:52] == grsf_pkg::EXP_ALL_ONES);
      status.raw_amp  = (kind_ff != grsf_pkg::KIND_OBJECTIVE) &&
                        grsf_pkg::fp_lt(grsf_pkg::DBL_ONE, raw_ff);
      status.div_done = div_done;
      status.out_free = !out_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_greatest_ff, out_least_ff, out_factor_ff};
   assign rsp_tuser  = out_kind_ff;
   assign csr_prdata = (csr_paddr[3] == grsf_pkg::REG_TARGET_PEAK) ? maxg_ff : lim_ff;

endmodule

// ===== hw/rtl/grsf_ctrl.sv =====
module grsf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  grsf_pkg::status_type status,
   output grsf_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_START, S_RAW, S_AMP, S_LO, S_PICK, S_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = state_ff == S_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            cmd.take_item = req_tvalid;
            if (req_tvalid && status.closes) begin
               state_in = S_START;
            end
         end
         S_START: begin
            if (status.norm_bad) begin
               cmd.set_one = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.start_raw = 1'b1;
               state_in      = S_RAW;
            end
         end
         S_RAW: begin
            if (status.div_done) begin
               cmd.take_raw = 1'b1;
               state_in     = S_AMP;
            end
         end
         S_AMP: begin
            if (status.raw_amp) begin
               cmd.set_one = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.start_lo = 1'b1;
               state_in     = S_LO;
            end
         end
         S_LO: begin
            if (status.div_done) begin
               cmd.take_lo = 1'b1;
               state_in    = S_PICK;
            end
         end
         S_PICK: begin
            cmd.pick = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
